// File: rtl/mwsm_pkg.sv
// ============================================================================
// mwsm_pkg
// Shared widths, register indexes, types and helper functions for the
// mecanum wheel speed mixer.
// ============================================================================
`default_nettype none

package mwsm_pkg;

    localparam int FLD_W    = 16;   // command and wheel field width
    localparam int LIM_W    = 15;   // limit register width
    localparam int SUM_W    = 18;   // full width wheel sum
    localparam int MAG_W    = 17;   // magnitude of a wheel sum
    localparam int PROD_W   = 32;   // magnitude times wheel limit
    localparam int Q_W      = 15;   // quotient width (result never exceeds limit)
    localparam int WHEELS   = 4;
    localparam int IDX_W    = 2;

    // start to done, in cycles
    localparam int PIPE_LAT = 21;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MAX_VX       = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_VY       = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_ROTATION = 2'd2;
    localparam logic [IDX_W-1:0] REG_WHEEL_LIMIT  = 2'd3;

    // reset values
    localparam logic [LIM_W-1:0] RST_MAX_VX       = 15'd14000;
    localparam logic [LIM_W-1:0] RST_MAX_VY       = 15'd14000;
    localparam logic [LIM_W-1:0] RST_MAX_ROTATION = 15'd10000;
    localparam logic [LIM_W-1:0] RST_WHEEL_LIMIT  = 15'd14000;

    typedef logic [MAG_W-1:0] mag_t;

    // per-item record carried alongside the divider
    typedef struct packed {
        logic [WHEELS-1:0]            neg;
        logic                         scale;
        logic [WHEELS-1:0][MAG_W-1:0] mag;
    } side_t;

    // symmetric clamp of a signed field to +/- lim
    function automatic logic signed [FLD_W-1:0] clamp_sym(
        input logic signed [FLD_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [FLD_W:0] v_e;
        logic signed [FLD_W:0] l_e;
        logic signed [FLD_W:0] r_e;
        v_e = {v[FLD_W-1], v};
        l_e = {2'b00, lim};
        if (v_e > l_e)
        begin
            r_e = l_e;
        end
        else if (v_e < -l_e)
        begin
            r_e = -l_e;
        end
        else
        begin
            r_e = v_e;
        end
        return r_e[FLD_W-1:0];
    endfunction

    // larger of two magnitudes
    function automatic mag_t mag_max(input mag_t a, input mag_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mwsm_front.sv
// ============================================================================
// mwsm_front
// Clamp, mix, magnitude and largest-magnitude stages (four register stages).
// ============================================================================
`default_nettype none

module mwsm_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic signed [mwsm_pkg::FLD_W-1:0] vel_x,
    input  wire logic signed [mwsm_pkg::FLD_W-1:0] vel_y,
    input  wire logic signed [mwsm_pkg::FLD_W-1:0] rotation,
    input  wire logic [mwsm_pkg::LIM_W-1:0]    max_vx,
    input  wire logic [mwsm_pkg::LIM_W-1:0]    max_vy,
    input  wire logic [mwsm_pkg::LIM_W-1:0]    max_rotation,
    input  wire logic [mwsm_pkg::LIM_W-1:0]    wheel_limit,
    output logic                               out_vld,
    output mwsm_pkg::side_t                    out_side,
    output mwsm_pkg::mag_t                     out_den
);
    import mwsm_pkg::*;

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic signed [FLD_W-1:0]  x_reg, y_reg, r_reg;
    logic signed [SUM_W-1:0]  sum_reg [WHEELS];
    logic signed [SUM_W-1:0]  sum_next [WHEELS];
    logic [WHEELS-1:0]        s3_neg_reg;
    mag_t                     s3_mag_reg [WHEELS];
    side_t                    s4_side_reg;
    mag_t                     s4_den_reg;
    logic signed [SUM_W-1:0]  xe, ye, re;
    mag_t                     big01, big23, big;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // stage 1: clamp
    always_ff @(posedge clk)
    begin
        x_reg <= clamp_sym(vel_x, max_vx);
        y_reg <= clamp_sym(vel_y, max_vy);
        r_reg <= clamp_sym(rotation, max_rotation);
    end

    // stage 2: full width mix
    always_comb
    begin
        xe = SUM_W'(x_reg);
        ye = SUM_W'(y_reg);
        re = SUM_W'(r_reg);
        sum_next[0] = -xe + ye - re;
        sum_next[1] = -xe - ye - re;
        sum_next[2] =  xe - ye - re;
        sum_next[3] =  xe + ye - re;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            sum_reg[i] <= sum_next[i];
        end
    end

    // stage 3: sign and magnitude
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            s3_neg_reg[i] <= sum_reg[i][SUM_W-1];
            s3_mag_reg[i] <= sum_reg[i][SUM_W-1] ? MAG_W'(-sum_reg[i])
                                                 : MAG_W'(sum_reg[i]);
        end
    end

    // stage 4: largest magnitude and scale decision
    always_comb
    begin
        big01 = mag_max(s3_mag_reg[0], s3_mag_reg[1]);
        big23 = mag_max(s3_mag_reg[2], s3_mag_reg[3]);
        big   = mag_max(big01, big23);
    end

    always_ff @(posedge clk)
    begin
        s4_den_reg        <= big;
        s4_side_reg.neg   <= s3_neg_reg;
        s4_side_reg.scale <= (big > MAG_W'(wheel_limit));
        for (int i = 0; i < WHEELS; i++)
        begin
            s4_side_reg.mag[i] <= s3_mag_reg[i];
        end
    end

    assign out_vld  = s4_vld_reg;
    assign out_side = s4_side_reg;
    assign out_den  = s4_den_reg;

endmodule

`default_nettype wire

// File: rtl/mwsm_div.sv
// ============================================================================
// mwsm_div
// Product stage and a restoring divider, one quotient bit per stage, four
// wheel lanes sharing one divisor.
// ============================================================================
`default_nettype none

module mwsm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_vld,
    input  wire mwsm_pkg::side_t            in_side,
    input  wire mwsm_pkg::mag_t             in_den,
    input  wire logic [mwsm_pkg::LIM_W-1:0] wheel_limit,
    output logic                            out_vld,
    output mwsm_pkg::side_t                 out_side,
    output logic [mwsm_pkg::WHEELS-1:0][mwsm_pkg::Q_W-1:0] out_quot
);
    import mwsm_pkg::*;

    // stage 0 holds the products, stage Q_W the finished quotients
    logic                 vld_reg  [Q_W+1];
    side_t                side_reg [Q_W+1];
    mag_t                 den_reg  [Q_W+1];
    logic [PROD_W-1:0]    rem_reg  [Q_W+1][WHEELS];
    logic [Q_W-1:0]       quo_reg  [Q_W+1][WHEELS];

    // stage 0: magnitude times limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
        end
    end

    // operands widened first so the product keeps all its bits
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        den_reg[0]  <= in_den;
        for (int w = 0; w < WHEELS; w++)
        begin
            rem_reg[0][w] <= PROD_W'(in_side.mag[w]) * PROD_W'(wheel_limit);
            quo_reg[0][w] <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        localparam int BIT = Q_W - 1 - s;
        logic [PROD_W-1:0] dsh;
        assign dsh = PROD_W'(den_reg[s]) << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[s+1] <= side_reg[s];
            den_reg[s+1]  <= den_reg[s];
            for (int w = 0; w < WHEELS; w++)
            begin
                if (rem_reg[s][w] >= dsh)
                begin
                    rem_reg[s+1][w] <= rem_reg[s][w] - dsh;
                    quo_reg[s+1][w] <= {quo_reg[s][w][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1][w] <= rem_reg[s][w];
                    quo_reg[s+1][w] <= {quo_reg[s][w][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_vld  = vld_reg[Q_W];
    assign out_side = side_reg[Q_W];

    always_comb
    begin
        for (int w = 0; w < WHEELS; w++)
        begin
            out_quot[w] = quo_reg[Q_W][w];
        end
    end

endmodule

`default_nettype wire

// File: rtl/mecanum_wheel_speed_mix_top.sv
// ============================================================================
// mecanum_wheel_speed_mix_top
// Mecanum inverse kinematics with clamping and proportional normalization.
// ============================================================================
// A command is taken on any cycle with start high; busy stays low, so one
// command per cycle is sustained. Each result appears on the wheel ports
// with done high for one cycle; each command passes four clamp/mix/max
// stages, a product stage, the 15-stage restoring divider (one quotient
// bit per stage) and the output register. Results come out in command
// order and cannot be held off. Configuration writes are always ready and
// take effect at once; write them only while no command is in flight.
`default_nettype none

module mecanum_wheel_speed_mix_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [mwsm_pkg::FLD_W-1:0] vel_x,
    input  wire logic signed [mwsm_pkg::FLD_W-1:0] vel_y,
    input  wire logic signed [mwsm_pkg::FLD_W-1:0] rotation,
    output logic                                   done,
    output logic signed [mwsm_pkg::FLD_W-1:0]      wheel_a,
    output logic signed [mwsm_pkg::FLD_W-1:0]      wheel_b,
    output logic signed [mwsm_pkg::FLD_W-1:0]      wheel_c,
    output logic signed [mwsm_pkg::FLD_W-1:0]      wheel_d,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mwsm_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [mwsm_pkg::LIM_W-1:0]        cfg_data
);
    import mwsm_pkg::*;

    logic [LIM_W-1:0] max_vx_reg, max_vy_reg, max_rot_reg, wheel_limit_reg;
    logic             front_vld, div_vld, done_reg;
    side_t            front_side, div_side;
    mag_t             front_den;
    logic [WHEELS-1:0][Q_W-1:0] div_quot;
    logic signed [FLD_W-1:0] wheel_reg  [WHEELS];
    logic signed [FLD_W-1:0] wheel_next [WHEELS];
    logic [FLD_W-1:0]        mag16;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vx_reg      <= RST_MAX_VX;
            max_vy_reg      <= RST_MAX_VY;
            max_rot_reg     <= RST_MAX_ROTATION;
            wheel_limit_reg <= RST_WHEEL_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_VX:       max_vx_reg      <= cfg_data;
                REG_MAX_VY:       max_vy_reg      <= cfg_data;
                REG_MAX_ROTATION: max_rot_reg     <= cfg_data;
                REG_WHEEL_LIMIT:  wheel_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    mwsm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (start && !busy),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .rotation     (rotation),
        .max_vx       (max_vx_reg),
        .max_vy       (max_vy_reg),
        .max_rotation (max_rot_reg),
        .wheel_limit  (wheel_limit_reg),
        .out_vld      (front_vld),
        .out_side     (front_side),
        .out_den      (front_den)
    );

    mwsm_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (front_vld),
        .in_side     (front_side),
        .in_den      (front_den),
        .wheel_limit (wheel_limit_reg),
        .out_vld     (div_vld),
        .out_side    (div_side),
        .out_quot    (div_quot)
    );

    // pick scaled or raw magnitude, then restore the sign
    always_comb
    begin
        mag16 = '0;
        for (int w = 0; w < WHEELS; w++)
        begin
            if (div_side.scale)
            begin
                mag16 = FLD_W'(div_quot[w]);
            end
            else
            begin
                mag16 = FLD_W'(div_side.mag[w][Q_W-1:0]);
            end
            wheel_next[w] = div_side.neg[w] ? -$signed(mag16) : $signed(mag16);
        end
    end

    // output register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < WHEELS; w++)
        begin
            wheel_reg[w] <= wheel_next[w];
        end
    end

    assign done    = done_reg;
    assign wheel_a = wheel_reg[0];
    assign wheel_b = wheel_reg[1];
    assign wheel_c = wheel_reg[2];
    assign wheel_d = wheel_reg[3];

`ifndef SYNTHESIS
    // every accepted transaction produces exactly one result at fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("result missing at expected latency");

    // no result without a transaction that caused it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result without a command");

    // wheel_a stays within the wheel limit
    a_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel_a <= $signed({1'b0, wheel_limit_reg}))
              && (wheel_a >= -$signed({1'b0, wheel_limit_reg})))
        else $error("wheel_a exceeds wheel limit");

    // wheel_d stays within the wheel limit
    a_range_d: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (wheel_d <= $signed({1'b0, wheel_limit_reg}))
              && (wheel_d >= -$signed({1'b0, wheel_limit_reg})))
        else $error("wheel_d exceeds wheel limit");
`endif

endmodule

`default_nettype wire

// File: tb/mecanum_wheel_speed_mix_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Mecanum wheel speed mixer testbench
// Sends directed commands and random bursts under several limit settings and
// checks the four wheel speeds against a local clamp/mix/normalize predictor.
// ============================================================================

module mecanum_wheel_speed_mix_top_tb;

    import mwsm_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RAND_PER_SET = 250;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic signed [FLD_W-1:0] a;
        logic signed [FLD_W-1:0] b;
        logic signed [FLD_W-1:0] c;
        logic signed [FLD_W-1:0] d;
    } wheel_set_t;

    typedef struct {
        logic signed [FLD_W-1:0] vx;
        logic signed [FLD_W-1:0] vy;
        logic signed [FLD_W-1:0] rot;
        bit                      known;
        wheel_set_t              wheels;
    } cmd_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [FLD_W-1:0] vel_x;
    logic signed [FLD_W-1:0] vel_y;
    logic signed [FLD_W-1:0] rotation;
    logic                    done;
    logic signed [FLD_W-1:0] wheel_a;
    logic signed [FLD_W-1:0] wheel_b;
    logic signed [FLD_W-1:0] wheel_c;
    logic signed [FLD_W-1:0] wheel_d;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index;
    logic [LIM_W-1:0]        cfg_data;

    // shadow of the limit registers
    logic [LIM_W-1:0] lim_vx;
    logic [LIM_W-1:0] lim_vy;
    logic [LIM_W-1:0] lim_rot;
    logic [LIM_W-1:0] lim_wheel;

    wheel_set_t pending_wheels[$];
    bit         pending_known[$];
    wheel_set_t pending_typed[$];
    int         error_count;
    int         cycle_count;
    bit         cur_known;
    wheel_set_t cur_typed;

    mecanum_wheel_speed_mix_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .rotation  (rotation),
        .done      (done),
        .wheel_a   (wheel_a),
        .wheel_b   (wheel_b),
        .wheel_c   (wheel_c),
        .wheel_d   (wheel_d),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // symmetric clamp at full width
    function automatic int limit_part(input logic signed [FLD_W-1:0] v,
                                      input logic [LIM_W-1:0] lim);
        int vi;
        int li;
        vi = v;
        li = lim;
        if (vi > li)
            return li;
        if (vi < -li)
            return -li;
        return vi;
    endfunction

    // clamp, mix and proportional scaling of one command
    function automatic wheel_set_t mix_wheels(input logic signed [FLD_W-1:0] vx,
                                              input logic signed [FLD_W-1:0] vy,
                                              input logic signed [FLD_W-1:0] rot);
        int         x;
        int         y;
        int         r;
        int         sum[4];
        longint     m;
        longint     peak;
        longint     q;
        wheel_set_t res;
        x = limit_part(vx, lim_vx);
        y = limit_part(vy, lim_vy);
        r = limit_part(rot, lim_rot);
        sum[0] = -x + y - r;
        sum[1] = -x - y - r;
        sum[2] = x - y - r;
        sum[3] = x + y - r;
        peak = 0;
        for (int i = 0; i < 4; i++)
        begin
            m = (sum[i] < 0) ? -sum[i] : sum[i];
            if (m > peak)
                peak = m;
        end
        if (peak > lim_wheel)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m = (sum[i] < 0) ? -sum[i] : sum[i];
                q = (m * lim_wheel) / peak;
                sum[i] = (sum[i] < 0) ? -int'(q) : int'(q);
            end
        end
        res.a = sum[0][FLD_W-1:0];
        res.b = sum[1][FLD_W-1:0];
        res.c = sum[2][FLD_W-1:0];
        res.d = sum[3][FLD_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_wheel(input string name, input logic signed [FLD_W-1:0] got,
                               input logic signed [FLD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // accept transactions, track config writes, check results
    always @(posedge clk)
    begin
        wheel_set_t w;
        bit         k;
        wheel_set_t t;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_VX:       lim_vx    <= cfg_data;
                REG_MAX_VY:       lim_vy    <= cfg_data;
                REG_MAX_ROTATION: lim_rot   <= cfg_data;
                REG_WHEEL_LIMIT:  lim_wheel <= cfg_data;
                default: ;
            endcase
        end
        if (rst_n && start && !busy)
        begin
            pending_wheels.push_back(mix_wheels(vel_x, vel_y, rotation));
            pending_known.push_back(cur_known);
            pending_typed.push_back(cur_typed);
        end
        if (rst_n && done)
        begin
            if (pending_wheels.size() == 0)
                report_mismatch("result with nothing outstanding");
            else
            begin
                w = pending_wheels.pop_front();
                k = pending_known.pop_front();
                t = pending_typed.pop_front();
                check_wheel("wheel_a", wheel_a, w.a);
                check_wheel("wheel_b", wheel_b, w.b);
                check_wheel("wheel_c", wheel_c, w.c);
                check_wheel("wheel_d", wheel_d, w.d);
                if (k)
                begin
                    check_wheel("table wheel_a", wheel_a, t.a);
                    check_wheel("table wheel_b", wheel_b, t.b);
                    check_wheel("table wheel_c", wheel_c, t.c);
                    check_wheel("table wheel_d", wheel_d, t.d);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input logic [LIM_W-1:0] vx, input logic [LIM_W-1:0] vy,
                              input logic [LIM_W-1:0] rot, input logic [LIM_W-1:0] wl);
        write_reg(REG_MAX_VX, vx);
        write_reg(REG_MAX_VY, vy);
        write_reg(REG_MAX_ROTATION, rot);
        write_reg(REG_WHEEL_LIMIT, wl);
    endtask

    // one command transaction; start stays high if another follows at once
    task automatic send_cmd(input logic signed [FLD_W-1:0] vx,
                            input logic signed [FLD_W-1:0] vy,
                            input logic signed [FLD_W-1:0] rot,
                            input bit known, input wheel_set_t typed);
        @(negedge clk);
        start     = 1'b1;
        vel_x     = vx;
        vel_y     = vy;
        rotation  = rot;
        cur_known = known;
        cur_typed = typed;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start     = 1'b0;
            cur_known = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (pending_wheels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    function automatic logic signed [FLD_W-1:0] rand_field();
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            1: return $signed(16'($urandom_range(0, 40000) - 20000));
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] rand_limit();
        case ($urandom_range(0, 3))
            0: return 15'($urandom_range(0, 3));
            1: return 15'h7FFF;
            default: return 15'($urandom);
        endcase
    endfunction

    // random commands in bursts with random gaps
    task automatic random_commands(input int count);
        wheel_set_t none;
        int         sent;
        int         burst;
        none = '{default: '0};
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_cmd(rand_field(), rand_field(), rand_field(), 1'b0, none);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    cmd_row_t cmd_table[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
        '{16'sd32767, 16'sd0, 16'sd0, 1'b1,
          '{-16'sd14000, -16'sd14000, 16'sd14000, 16'sd14000}},
        '{-16'sd32768, 16'sd0, 16'sd0, 1'b1,
          '{16'sd14000, 16'sd14000, -16'sd14000, -16'sd14000}},
        '{16'sd0, 16'sd32767, 16'sd0, 1'b1,
          '{16'sd14000, -16'sd14000, -16'sd14000, 16'sd14000}},
        '{16'sd0, -16'sd32768, 16'sd0, 1'b1,
          '{-16'sd14000, 16'sd14000, 16'sd14000, -16'sd14000}},
        '{16'sd0, 16'sd0, 16'sd32767, 1'b1,
          '{-16'sd10000, -16'sd10000, -16'sd10000, -16'sd10000}},
        '{16'sd0, 16'sd0, -16'sd32768, 1'b1,
          '{16'sd10000, 16'sd10000, 16'sd10000, 16'sd10000}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{default: '0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{default: '0}},
        '{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '{default: '0}},
        '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '{default: '0}},
        '{16'sd7000, 16'sd7000, 16'sd0, 1'b1,
          '{16'sd0, -16'sd14000, 16'sd0, 16'sd14000}},
        '{16'sd7001, 16'sd7000, 16'sd1, 1'b0, '{default: '0}},
        '{16'sd1, -16'sd1, 16'sd1, 1'b0, '{default: '0}},
        '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '{default: '0}},
        '{16'sd12345, -16'sd4321, 16'sd9999, 1'b0, '{default: '0}}
    };

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        vel_x       = '0;
        vel_y       = '0;
        rotation    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MAX_VX;
        cfg_data    = '0;
        cur_known   = 1'b0;
        cur_typed   = '{default: '0};
        error_count = 0;
        cycle_count = 0;
        lim_vx      = RST_MAX_VX;
        lim_vy      = RST_MAX_VY;
        lim_rot     = RST_MAX_ROTATION;
        lim_wheel   = RST_WHEEL_LIMIT;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed commands at reset limits
        foreach (cmd_table[i])
        begin
            send_cmd(cmd_table[i].vx, cmd_table[i].vy, cmd_table[i].rot,
                     cmd_table[i].known, cmd_table[i].wheels);
            if (i % 5 == 4)
                idle_cycles(2);
        end
        drain();

        // reset limits, then extremes, then random settings
        random_commands(RAND_PER_SET);
        drain();
        set_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        random_commands(RAND_PER_SET);
        drain();
        set_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0);
        random_commands(100);
        drain();
        set_limits(15'd0, 15'd0, 15'd0, 15'd0);
        random_commands(50);
        drain();
        set_limits(15'd0, 15'd5000, 15'h7FFF, 15'd1);
        random_commands(100);
        drain();
        for (int p = 0; p < 3; p++)
        begin
            set_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit());
            random_commands(RAND_PER_SET);
            drain();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
